// File: sv/est_pkg.sv
// Shared types and constants for the escape string translator.
`default_nettype none

package est_pkg;

    // Width of the output byte counter and of the output limit register
    localparam int LIMIT_BITS_DEF = 29;

    // Reset value of the output limit, truncated to the counter width where it is used
    localparam logic [31:0] OUT_LIMIT_RESET = 32'd256;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COPY_QUOTES  = 2'd0,
        CFG_IGNORE_CTRL  = 2'd1,
        CFG_SPACE_TERM   = 2'd2,
        CFG_OUT_LIMIT    = 2'd3
    } cfg_addr_t;

    // Completion status codes
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_BUF_FULL     = 4'd1,
        ST_NO_BAR_CHAR  = 4'd2,
        ST_BAD_BAR_CHAR = 4'd3,
        ST_TOPBIT_ANGLE = 4'd4,
        ST_BAD_NAME     = 4'd5,
        ST_NO_CLOSE     = 4'd6,
        ST_OPEN_QUOTE   = 4'd7,
        ST_TOPBIT_END   = 4'd8
    } status_t;

    // Result packing: tdata = {out_count, status, out_byte}, tuser = {var_ref, byte_valid}
    localparam int OUT_BYTE_LSB   = 0;
    localparam int OUT_STATUS_LSB = 8;
    localparam int OUT_COUNT_LSB  = 12;
    localparam int TUSER_VALID    = 0;
    localparam int TUSER_VAR      = 1;

endpackage

`default_nettype wire

// File: sv/escape_string_translator_top.sv
// Escape string translator: one input character in, one result transaction out.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------------
//  s_       | in  | s_tvalid/tready  | tdata: ch[7:0]; tuser: start_req
//  m_       | out | m_tvalid/tready  | tdata: out_byte, status, out_count; tuser:
//           |     |                  | byte_valid, var_ref; tlast: done_res
//  cfg_     | in  | cfg_we           | cfg_addr index, cfg_wdata value
//
// One character per cycle sustained while m_tready stays high; each result passes
// through the input register and the translate logic into the result register.
// The base multiply-add in the angle number path sets the longest path.
// aresetn (synchronous) clears the translation state and the configuration registers.
// With m_tready low the result register holds; one more transaction waits in
// the input register, then s_tready drops.
`default_nettype none

module escape_string_translator_top #(
    parameter int LIMIT_BITS = est_pkg::LIMIT_BITS_DEF,
    localparam int M_DATA_W  = ((est_pkg::OUT_COUNT_LSB + LIMIT_BITS + 7) / 8) * 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input channel
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] ch
    input  wire logic                        s_tuser,   // [0] start_req
    // result channel
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [M_DATA_W-1:0]              m_tdata,   // [7:0] out_byte, [11:8] status,
                                                        // then out_count, zero pad
    output logic [1:0]                       m_tuser,   // [0] byte_valid, [1] var_ref
    output logic                             m_tlast,   // done_res
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [est_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [LIMIT_BITS-1:0]       cfg_wdata
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_LBRC  = 8'h7b;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_RBRC  = 8'h7d;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    localparam logic [7:0] CTRL_ESC = 8'd27;
    localparam logic [7:0] CTRL_FS  = 8'd28;
    localparam logic [7:0] CTRL_GS  = 8'd29;
    localparam logic [7:0] CTRL_RS  = 8'd30;
    localparam logic [7:0] CTRL_US  = 8'd31;
    localparam logic [7:0] TOP_BIT  = 8'h80;

    localparam logic [5:0]  BASE_DEC = 6'd10;
    localparam logic [5:0]  BASE_HEX = 6'd16;
    localparam logic [31:0] BASE_MAX = 32'd36;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_LEAD  = 6'b000010,
        PH_MAIN  = 6'b000100,
        PH_BAR   = 6'b001000,
        PH_ANGLE = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    // configuration
    logic                  copy_quotes_reg;
    logic                  ignore_ctrl_reg;
    logic                  space_term_reg;
    logic [LIMIT_BITS-1:0] out_limit_reg;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] ch_reg;
    logic       start_reg;

    // translation state
    phase_t                phase_reg, phase_next;
    logic                  inq_reg, inq_next;
    logic                  tbp_reg, tbp_next;
    logic [31:0]           av_reg, av_next;
    logic [5:0]            ab_reg, ab_next;
    logic                  an_reg, an_next;
    logic                  af_reg, af_next;
    logic [LIMIT_BITS-1:0] bw_reg, bw_next;

    // result register
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [1:0]            m_tuser_reg;
    logic                  m_tlast_reg;

    // translate logic
    logic                  r_valid, r_var, r_done;
    logic [7:0]            r_byte;
    est_pkg::status_t      r_status;
    logic                  do_emit, do_finish, main_go;
    logic [7:0]            emit_val, bar_val;
    est_pkg::status_t      fin_status;
    logic                  term, at_limit;
    logic                  is_upper, is_lower, is_digit;
    logic [5:0]            dig_raw, base_eff;
    logic                  dig_ok;

    logic out_free, advance;

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // character classes
    always_comb begin
        is_upper = (ch_reg >= 8'h41) && (ch_reg <= 8'h5a);
        is_lower = (ch_reg >= 8'h61) && (ch_reg <= 8'h7a);
        is_digit = (ch_reg >= 8'h30) && (ch_reg <= 8'h39);
        if (is_digit) begin
            dig_raw = 6'(ch_reg - 8'h30);
        end else if (is_upper) begin
            dig_raw = 6'(ch_reg - 8'h41 + 8'd10);
        end else begin
            dig_raw = 6'(ch_reg - 8'h61 + 8'd10);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        inq_next   = inq_reg;
        tbp_next   = tbp_reg;
        av_next    = av_reg;
        ab_next    = ab_reg;
        an_next    = an_reg;
        af_next    = af_reg;
        bw_next    = bw_reg;
        r_valid    = 1'b0;
        r_byte     = '0;
        r_var      = 1'b0;
        r_done     = 1'b0;
        r_status   = est_pkg::ST_OK;
        do_emit    = 1'b0;
        do_finish  = 1'b0;
        main_go    = 1'b0;
        emit_val   = '0;
        bar_val    = '0;
        fin_status = est_pkg::ST_OK;

        if (start_reg) begin
            phase_next = PH_LEAD;
            inq_next   = 1'b0;
            tbp_next   = 1'b0;
            av_next    = '0;
            ab_next    = '0;
            an_next    = 1'b1;
            af_next    = 1'b1;
            bw_next    = '0;
        end

        term = (ch_reg == CH_NUL) || (ch_reg == CH_CR) || (ch_reg == CH_LF) ||
               (space_term_reg && !inq_next && (ch_reg == CH_SPACE));
        at_limit = bw_next >= out_limit_reg;
        base_eff = (ab_next == '0) ? BASE_DEC : ab_next;
        dig_ok   = (is_digit || is_upper || is_lower) && (dig_raw < base_eff);

        unique case (phase_next)
            PH_LEAD: begin
                if (ch_reg != CH_SPACE) begin
                    phase_next = PH_MAIN;
                    if (ch_reg == CH_QUOTE && !copy_quotes_reg) begin
                        inq_next = 1'b1;
                        if (at_limit) begin
                            do_finish  = 1'b1;
                            fin_status = est_pkg::ST_OPEN_QUOTE;
                        end
                    end else begin
                        main_go = 1'b1;
                    end
                end
            end
            PH_MAIN: begin
                main_go = 1'b1;
            end
            PH_BAR: begin
                if (term) begin
                    do_finish  = 1'b1;
                    fin_status = est_pkg::ST_NO_BAR_CHAR;
                end else if (is_upper || is_lower) begin
                    do_emit  = 1'b1;
                    emit_val = {3'b000, ch_reg[4:0]};
                end else begin
                    do_emit = 1'b1;
                    unique case (ch_reg)
                        CH_AT:              bar_val = '0;
                        CH_LBRK, CH_LBRC:   bar_val = CTRL_ESC;
                        CH_BSL:             bar_val = CTRL_FS;
                        CH_RBRK, CH_RBRC:   bar_val = CTRL_GS;
                        CH_CARET, CH_TILDE: bar_val = CTRL_RS;
                        CH_UNDER, CH_APOS:  bar_val = CTRL_US;
                        CH_QUOTE, CH_BAR, CH_LT: bar_val = ch_reg;
                        CH_QMARK:           bar_val = CH_DEL;
                        CH_BANG: begin
                            do_emit    = 1'b0;
                            tbp_next   = 1'b1;
                            phase_next = PH_MAIN;
                        end
                        default: begin
                            do_emit    = 1'b0;
                            do_finish  = 1'b1;
                            fin_status = est_pkg::ST_BAD_BAR_CHAR;
                        end
                    endcase
                    emit_val = bar_val;
                end
            end
            PH_ANGLE: begin
                af_next = 1'b0;
                if (af_reg && ch_reg == CH_AMP) begin
                    ab_next = BASE_HEX;
                end else if (ch_reg == CH_GT) begin
                    if (an_next) begin
                        do_emit  = 1'b1;
                        emit_val = av_next[7:0];
                    end else begin
                        r_var      = 1'b1;
                        phase_next = PH_MAIN;
                    end
                end else if (term) begin
                    do_finish  = 1'b1;
                    fin_status = est_pkg::ST_NO_CLOSE;
                end else if (ch_reg <= CH_SPACE) begin
                    do_finish  = 1'b1;
                    fin_status = est_pkg::ST_BAD_NAME;
                end else if (ch_reg == CH_UNDER && ab_next == '0 && an_next &&
                             av_next > 32'd1 && av_next <= BASE_MAX) begin
                    ab_next = av_next[5:0];
                    av_next = '0;
                end else if (!dig_ok) begin
                    an_next = 1'b0;
                end else if (an_next) begin
                    av_next = av_next * {26'd0, base_eff} + {26'd0, dig_raw};
                end
            end
            default: ;
        endcase

        if (main_go) begin
            priority if (at_limit) begin
                do_finish  = 1'b1;
                fin_status = inq_next ? est_pkg::ST_OPEN_QUOTE :
                             (tbp_next ? est_pkg::ST_TOPBIT_END : est_pkg::ST_BUF_FULL);
            end else if (term) begin
                do_finish  = 1'b1;
                fin_status = inq_next ? est_pkg::ST_OPEN_QUOTE :
                             (tbp_next ? est_pkg::ST_TOPBIT_END : est_pkg::ST_OK);
            end else if (inq_next && ch_reg == CH_QUOTE) begin
                do_finish  = 1'b1;
                fin_status = tbp_next ? est_pkg::ST_TOPBIT_END : est_pkg::ST_OK;
            end else if (ch_reg == CH_BAR && !ignore_ctrl_reg) begin
                phase_next = PH_BAR;
            end else if (ch_reg == CH_LT) begin
                if (tbp_next) begin
                    do_finish  = 1'b1;
                    fin_status = est_pkg::ST_TOPBIT_ANGLE;
                end else begin
                    phase_next = PH_ANGLE;
                    av_next    = '0;
                    ab_next    = '0;
                    an_next    = 1'b1;
                    af_next    = 1'b1;
                end
            end else begin
                do_emit  = 1'b1;
                emit_val = ch_reg;
            end
        end

        if (do_emit) begin
            r_valid    = 1'b1;
            r_byte     = tbp_next ? (emit_val | TOP_BIT) : emit_val;
            tbp_next   = 1'b0;
            bw_next    = bw_next + LIMIT_BITS'(1);
            phase_next = PH_MAIN;
            if (bw_next >= out_limit_reg) begin
                do_finish  = 1'b1;
                fin_status = inq_next ? est_pkg::ST_OPEN_QUOTE : est_pkg::ST_BUF_FULL;
            end
        end

        if (do_finish) begin
            r_done     = 1'b1;
            r_status   = fin_status;
            phase_next = PH_DONE;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_quotes_reg <= 1'b0;
            ignore_ctrl_reg <= 1'b0;
            space_term_reg  <= 1'b0;
            out_limit_reg   <= LIMIT_BITS'(est_pkg::OUT_LIMIT_RESET);
        end else if (cfg_we) begin
            unique case (est_pkg::cfg_addr_t'(cfg_addr))
                est_pkg::CFG_COPY_QUOTES: copy_quotes_reg <= cfg_wdata[0];
                est_pkg::CFG_IGNORE_CTRL: ignore_ctrl_reg <= cfg_wdata[0];
                est_pkg::CFG_SPACE_TERM:  space_term_reg  <= cfg_wdata[0];
                est_pkg::CFG_OUT_LIMIT:   out_limit_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            inq_reg      <= 1'b0;
            tbp_reg      <= 1'b0;
            av_reg       <= '0;
            ab_reg       <= '0;
            an_reg       <= 1'b1;
            af_reg       <= 1'b1;
            bw_reg       <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_tvalid_reg <= s1_valid_reg;
            end
            if (advance) begin
                phase_reg <= phase_next;
                inq_reg   <= inq_next;
                tbp_reg   <= tbp_next;
                av_reg    <= av_next;
                ab_reg    <= ab_next;
                an_reg    <= an_next;
                af_reg    <= af_next;
                bw_reg    <= bw_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ch_reg    <= s_tdata;
            start_reg <= s_tuser;
        end
        if (advance) begin
            m_tdata_reg <= M_DATA_W'({bw_next, r_status, r_byte});
            m_tuser_reg <= {r_var, r_valid};
            m_tlast_reg <= r_done;
        end
    end

endmodule

`default_nettype wire

// File: sv/est_checker.sv
// Port-level checks on the translator result channel, bound to the top level.
`default_nettype none

module est_checker #(
    parameter int LIMIT_BITS = est_pkg::LIMIT_BITS_DEF,
    localparam int M_DATA_W  = ((est_pkg::OUT_COUNT_LSB + LIMIT_BITS + 7) / 8) * 8
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [1:0]          m_tuser,
    input wire logic                m_tlast
);

    logic [3:0] status;
    logic [7:0] out_byte;

    assign status   = m_tdata[est_pkg::OUT_STATUS_LSB +: 4];
    assign out_byte = m_tdata[est_pkg::OUT_BYTE_LSB +: 8];

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("result changed while stalled");

    // status is only reported on the finishing transaction
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> status == est_pkg::ST_OK)
        else $error("status without done");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status <= est_pkg::ST_TOPBIT_END)
        else $error("status code out of range");

    // a byte and a variable reference never share a transaction
    a_byte_var: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[est_pkg::TUSER_VALID] |-> !m_tuser[est_pkg::TUSER_VAR])
        else $error("byte with var_ref");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[est_pkg::TUSER_VALID] |-> out_byte == 8'h00)
        else $error("out_byte set without byte_valid");

endmodule

bind escape_string_translator_top est_checker #(.LIMIT_BITS(LIMIT_BITS)) u_est_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/tb_escape_string_translator_top.sv
// Self-checking testbench for the escape string translator stream block.
`timescale 1ns / 1ps

module tb_escape_string_translator_top;

    localparam int CNT_W       = 29;
    localparam int RES_W       = ((est_pkg::OUT_COUNT_LSB + CNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic [2:0] {
        TR_IDLE, TR_LEAD, TR_MAIN, TR_BAR, TR_ANGLE, TR_DONE
    } tr_phase_t;

    typedef struct {
        logic [7:0] ch;
        logic       start;
    } raw_char_t;

    typedef struct {
        logic             valid;
        logic [7:0]       chr;
        logic             var_ref;
        logic             done;
        est_pkg::status_t status;
        logic [CNT_W-1:0] count;
    } xlat_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [RES_W-1:0]      m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    est_pkg::cfg_addr_t    cfg_addr  = est_pkg::CFG_COPY_QUOTES;
    logic [CNT_W-1:0]      cfg_wdata = '0;

    escape_string_translator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Translation predictor: configuration and state
    // ---------------------------------------------------------------
    logic             cp_quotes, no_ctrl, sp_term;
    logic [CNT_W-1:0] lim;
    tr_phase_t        ph;
    logic             quoted, top_pend, ang_num, ang_first;
    logic [31:0]      ang_val;
    logic [5:0]       ang_base;
    logic [CNT_W-1:0] nbytes;
    xlat_result_t     nx;

    raw_char_t    pending_chars[$];
    xlat_result_t predicted_outputs[$];

    bit    calm = 1'b0;
    bit    fresh = 1'b0;
    int    queued = 0;
    int    mismatches = 0;
    int    send_wait = 0;
    int    recv_wait = 0;
    int    stall;
    int    cycles = 0;
    string bar_chars = "ABMZamz@[{\\]}^~_'\"|<?!";

    function automatic bit term_char(logic [7:0] c);
        return c == 8'h00 || c == 8'h0d || c == 8'h0a ||
               (sp_term && !quoted && c == " ");
    endfunction

    function automatic void finish_with(est_pkg::status_t st);
        nx.done   = 1'b1;
        nx.status = st;
        ph        = TR_DONE;
    endfunction

    function automatic void put_byte(logic [7:0] c);
        if (top_pend) begin
            c        = c | 8'h80;
            top_pend = 1'b0;
        end
        nx.valid = 1'b1;
        nx.chr   = c;
        nbytes   = nbytes + CNT_W'(1);
        ph       = TR_MAIN;
        if (nbytes >= lim)
            finish_with(quoted ? est_pkg::ST_OPEN_QUOTE : est_pkg::ST_BUF_FULL);
    endfunction

    function automatic void main_ch(logic [7:0] c);
        if (nbytes >= lim) begin
            finish_with(quoted ? est_pkg::ST_OPEN_QUOTE :
                        (top_pend ? est_pkg::ST_TOPBIT_END : est_pkg::ST_BUF_FULL));
        end else if (term_char(c)) begin
            finish_with(quoted ? est_pkg::ST_OPEN_QUOTE :
                        (top_pend ? est_pkg::ST_TOPBIT_END : est_pkg::ST_OK));
        end else if (quoted && c == "\"") begin
            finish_with(top_pend ? est_pkg::ST_TOPBIT_END : est_pkg::ST_OK);
        end else if (c == "|" && !no_ctrl) begin
            ph = TR_BAR;
        end else if (c == "<") begin
            if (top_pend) begin
                finish_with(est_pkg::ST_TOPBIT_ANGLE);
            end else begin
                ph        = TR_ANGLE;
                ang_val   = '0;
                ang_base  = '0;
                ang_num   = 1'b1;
                ang_first = 1'b1;
            end
        end else begin
            put_byte(c);
        end
    endfunction

    function automatic xlat_result_t translate_char(logic [7:0] c, logic start);
        logic [7:0]  v;
        logic        ok;
        logic        first;
        logic [31:0] b, d;
        nx.valid   = 1'b0;
        nx.chr     = 8'h00;
        nx.var_ref = 1'b0;
        nx.done    = 1'b0;
        nx.status  = est_pkg::ST_OK;
        if (start) begin
            ph        = TR_LEAD;
            quoted    = 1'b0;
            top_pend  = 1'b0;
            ang_val   = '0;
            ang_base  = '0;
            ang_num   = 1'b1;
            ang_first = 1'b1;
            nbytes    = '0;
        end
        case (ph)
            TR_LEAD: begin
                if (c != " ") begin
                    if (c == "\"" && !cp_quotes) begin
                        quoted = 1'b1;
                        ph     = TR_MAIN;
                        if (nbytes >= lim)
                            finish_with(est_pkg::ST_OPEN_QUOTE);
                    end else begin
                        ph = TR_MAIN;
                        main_ch(c);
                    end
                end
            end
            TR_MAIN: main_ch(c);
            TR_BAR: begin
                if (term_char(c)) begin
                    finish_with(est_pkg::ST_NO_BAR_CHAR);
                end else if (c == "!") begin
                    top_pend = 1'b1;
                    ph       = TR_MAIN;
                end else begin
                    ok = 1'b1;
                    v  = 8'h00;
                    if (c >= "A" && c <= "Z")
                        v = c - "A" + 8'd1;
                    else if (c >= "a" && c <= "z")
                        v = c - "a" + 8'd1;
                    else
                        case (c)
                            "@":           v = 8'd0;
                            "[", "{":      v = 8'd27;
                            "\\":          v = 8'd28;
                            "]", "}":      v = 8'd29;
                            "^", "~":      v = 8'd30;
                            "_", "'":      v = 8'd31;
                            "\"", "|", "<": v = c;
                            "?":           v = 8'h7f;
                            default:       ok = 1'b0;
                        endcase
                    if (ok)
                        put_byte(v);
                    else
                        finish_with(est_pkg::ST_BAD_BAR_CHAR);
                end
            end
            TR_ANGLE: begin
                first     = ang_first;
                ang_first = 1'b0;
                if (first && c == "&") begin
                    ang_base = 6'd16;
                end else if (c == ">") begin
                    if (ang_num) begin
                        put_byte(ang_val[7:0]);
                    end else begin
                        nx.var_ref = 1'b1;
                        ph         = TR_MAIN;
                    end
                end else if (term_char(c)) begin
                    finish_with(est_pkg::ST_NO_CLOSE);
                end else if (c <= 8'd32) begin
                    finish_with(est_pkg::ST_BAD_NAME);
                end else if (c == "_" && ang_base == 6'd0 && ang_num &&
                             ang_val > 32'd1 && ang_val <= 32'd36) begin
                    ang_base = ang_val[5:0];
                    ang_val  = '0;
                end else begin
                    b = (ang_base == 6'd0) ? 32'd10 : 32'(ang_base);
                    if (c >= "0" && c <= "9")
                        d = 32'(c - "0");
                    else if (c >= "A" && c <= "Z")
                        d = 32'(c - "A") + 32'd10;
                    else if (c >= "a" && c <= "z")
                        d = 32'(c - "a") + 32'd10;
                    else
                        d = 32'd99;
                    if (d >= b)
                        ang_num = 1'b0;
                    if (ang_num)
                        ang_val = ang_val * b + d;
                end
            end
            default: ;
        endcase
        nx.count = nbytes;
        return nx;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int pick_wait();
        if (calm)
            return 0;
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic void add_char(logic [7:0] c);
        pending_chars.push_back('{ch: c, start: fresh});
        fresh  = 1'b0;
        queued = queued + 1;
    endfunction

    function automatic void push_text(string s);
        foreach (s[i])
            add_char(s[i]);
    endfunction

    function automatic logic [7:0] digit_char(int v);
        if (v < 10)
            return 8'("0" + v);
        return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    // one string: mostly well formed with random content, some raw noise
    task automatic gen_string();
        int n, r, b;
        bit quoted_s;
        fresh = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                fresh = ($urandom_range(0, 3) == 0);
                add_char(8'($urandom_range(0, 255)));
            end
            return;
        end
        repeat ($urandom_range(0, 3)) add_char(" ");
        quoted_s = 1'($urandom_range(0, 1));
        if (quoted_s)
            add_char("\"");
        n = $urandom_range(0, 10);
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r <= 3) begin
                add_char(8'($urandom_range(33, 255)));
            end else if (r <= 5) begin
                add_char("|");
                if ($urandom_range(0, 7) == 0)
                    add_char(8'($urandom_range(0, 255)));
                else
                    add_char(bar_chars[$urandom_range(0, bar_chars.len() - 1)]);
            end else if (r <= 8) begin
                add_char("<");
                case ($urandom_range(0, 7))
                    0: repeat ($urandom_range(1, 3)) add_char(digit_char($urandom_range(0, 9)));
                    1: begin
                        add_char("&");
                        repeat ($urandom_range(1, 3)) add_char(digit_char($urandom_range(0, 15)));
                    end
                    2, 3: begin
                        b = $urandom_range(2, 36);
                        if (b >= 10)
                            add_char(8'("0" + b / 10));
                        add_char(8'("0" + b % 10));
                        add_char("_");
                        repeat ($urandom_range(1, 4)) add_char(digit_char($urandom_range(0, b - 1)));
                    end
                    4: repeat ($urandom_range(1, 4))
                        add_char($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : "_");
                    5: repeat (10) add_char(digit_char($urandom_range(0, 9)));   // wraps 32 bits
                    6: ;
                    default: add_char(8'($urandom_range(0, 255)));
                endcase
                if ($urandom_range(0, 7) != 0)
                    add_char(">");
            end else begin
                add_char($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(1, 31)));
            end
        end
        if (quoted_s && $urandom_range(0, 4) != 0) begin
            add_char("\"");
        end else begin
            case ($urandom_range(0, 3))
                0:       add_char(8'h00);
                1:       add_char(8'h0d);
                2:       add_char(8'h0a);
                default: add_char(" ");
            endcase
        end
    endtask

    task automatic write_reg(est_pkg::cfg_addr_t idx, logic [CNT_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            est_pkg::CFG_COPY_QUOTES: cp_quotes = val[0];
            est_pkg::CFG_IGNORE_CTRL: no_ctrl   = val[0];
            est_pkg::CFG_SPACE_TERM:  sp_term   = val[0];
            est_pkg::CFG_OUT_LIMIT:   lim       = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until every result is back
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_chars.size() != 0 || s_tvalid || predicted_outputs.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Driver: feeds pending characters, predicts on each transaction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= 8'h00;
            s_tuser   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_outputs.push_back(translate_char(s_tdata, s_tuser));
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= pending_chars[0].ch;
                    s_tuser   <= pending_chars[0].start;
                    void'(pending_chars.pop_front());
                    send_wait <= pick_wait();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each result transaction with the oldest prediction
    // ---------------------------------------------------------------
    xlat_result_t            seen, want;
    logic [RES_W-est_pkg::OUT_COUNT_LSB-CNT_W-1:0] seen_pad;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            seen.valid   = m_tuser[est_pkg::TUSER_VALID];
            seen.var_ref = m_tuser[est_pkg::TUSER_VAR];
            seen.done    = m_tlast;
            seen.chr     = m_tdata[est_pkg::OUT_BYTE_LSB +: 8];
            seen.status  = est_pkg::status_t'(m_tdata[est_pkg::OUT_STATUS_LSB +: 4]);
            seen.count   = m_tdata[est_pkg::OUT_COUNT_LSB +: CNT_W];
            seen_pad     = m_tdata[RES_W-1:est_pkg::OUT_COUNT_LSB+CNT_W];
            if (predicted_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result transaction: tdata=%h tuser=%b tlast=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
            end else begin
                want = predicted_outputs.pop_front();
                if (seen.valid !== want.valid || seen.chr !== want.chr ||
                    seen.var_ref !== want.var_ref || seen.done !== want.done ||
                    seen.status !== want.status || seen.count !== want.count ||
                    seen_pad !== '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] mismatch: exp valid=%b byte=%h var=%b done=%b st=%0d cnt=%0d",
                                 $realtime, want.valid, want.chr, want.var_ref, want.done,
                                 want.status, want.count);
                        $display("    got valid=%b byte=%h var=%b done=%b st=%0d cnt=%0d pad=%h",
                                 seen.valid, seen.chr, seen.var_ref, seen.done,
                                 seen.status, seen.count, seen_pad);
                    end
                end
            end
            stall = pick_wait();
            recv_wait <= stall;
            m_tready  <= (stall == 0);
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            m_tready  <= (recv_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed strings, then register settings with random strings
    // ---------------------------------------------------------------
    initial begin : stimulus
        int               phase_no;
        int               phase_base;
        int               chunk_end;
        logic             q_bit, c_bit, s_bit;
        logic [CNT_W-1:0] l_val;

        cp_quotes = 1'b0;
        no_ctrl   = 1'b0;
        sp_term   = 1'b0;
        lim       = CNT_W'(est_pkg::OUT_LIMIT_RESET);
        ph        = TR_IDLE;
        quoted    = 1'b0;
        top_pend  = 1'b0;
        ang_val   = '0;
        ang_base  = '0;
        ang_num   = 1'b1;
        ang_first = 1'b1;
        nbytes    = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // leading spaces, outer quotes, top bit on the next char
        fresh = 1'b1;
        push_text("  \"|!a\"");
        // hex wraps to its low byte, base prefix, a variable name, CR ends
        fresh = 1'b1;
        push_text("<&1ff><3_12><q>\015");
        fresh = 1'b1;
        push_text("|!<");
        add_char(8'hff);                   // ignored, translation already over
        fresh = 1'b1;
        add_char("|");
        add_char(8'h00);
        wait_idle();

        for (phase_no = 0; phase_no < 8; phase_no++) begin
            // leave a string open across the register writes
            fresh = 1'b1;
            push_text("xy");
            wait_idle();
            case (phase_no)
                0: begin q_bit = 1'b0; c_bit = 1'b0; s_bit = 1'b0; l_val = CNT_W'(256); end
                1: begin q_bit = 1'b1; c_bit = 1'b1; s_bit = 1'b1; l_val = '0; end
                2: begin q_bit = 1'b0; c_bit = 1'b0; s_bit = 1'b1; l_val = '1; end
                3: begin q_bit = 1'b1; c_bit = 1'b0; s_bit = 1'b0; l_val = CNT_W'(1); end
                default: begin
                    q_bit = 1'($urandom_range(0, 1));
                    c_bit = 1'($urandom_range(0, 1));
                    s_bit = 1'($urandom_range(0, 1));
                    l_val = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 2))
                                                        : CNT_W'($urandom_range(3, 40));
                end
            endcase
            write_reg(est_pkg::CFG_COPY_QUOTES, CNT_W'(q_bit));
            write_reg(est_pkg::CFG_IGNORE_CTRL, CNT_W'(c_bit));
            write_reg(est_pkg::CFG_SPACE_TERM, CNT_W'(s_bit));
            write_reg(est_pkg::CFG_OUT_LIMIT, l_val);
            fresh = 1'b0;
            add_char("z");

            phase_base = queued;
            while (queued - phase_base < 200) begin
                chunk_end = queued + 50;
                while (queued < chunk_end)
                    gen_string();
                while (pending_chars.size() != 0)
                    @(negedge aclk);
                calm = ($urandom_range(0, 3) == 0);
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
sv/est_pkg.sv
sv/escape_string_translator_top.sv
sv/est_checker.sv
tb/tb_escape_string_translator_top.sv
